### hdl/slr_pkg.sv
// Shared constants for the stereo linear resampler.
package slr_pkg;

    // Fixed-point format of phase and step
    localparam int FRAC_BITS    = 16;
    localparam int ONE          = 1 << FRAC_BITS;

    // Block limits
    localparam int MAX_FRAMES   = 1024;
    localparam int MAX_UPSAMPLE = 8;
    localparam int MAX_RESULTS  = 18;

    // Field widths
    localparam int SAMPLE_W     = 16;
    localparam int BLOCK_W      = 11;
    localparam int OUT_W        = 14;
    localparam int STEP_W       = BLOCK_W + FRAC_BITS;        // unsigned Q.16 step
    localparam int PHASE_W      = 1 + BLOCK_W + FRAC_BITS;    // signed phase
    localparam int SAVED_W      = FRAC_BITS + 2;              // signed, [-ONE, 0]
    localparam int FRAC_W       = FRAC_BITS + 1;              // mix weight, [0, ONE]
    localparam int MIX_W        = SAMPLE_W + 1 + FRAC_W + 1;  // mix accumulator
    localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
    localparam int DIV_CNT_W    = $clog2(STEP_W);

    // Input kinds carried on tuser
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

endpackage

### hdl/slr_div.sv
// Restoring divider, one quotient bit per cycle, for the block phase step.
module slr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [slr_pkg::STEP_W-1:0]  dividend,
    input  logic [slr_pkg::OUT_W-1:0]   divisor,
    output logic                        done,
    output logic [slr_pkg::STEP_W-1:0]  quotient
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [slr_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [slr_pkg::STEP_W-1:0]       quo_reg;
    logic [slr_pkg::OUT_W:0]          rem_reg;
    logic [slr_pkg::OUT_W-1:0]        dsr_reg;

    logic [slr_pkg::OUT_W:0]          trial;
    logic                             fits;
    logic [slr_pkg::OUT_W:0]          rem_next;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        trial    = {rem_reg[slr_pkg::OUT_W-1:0], quo_reg[slr_pkg::STEP_W-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? (trial - {1'b0, dsr_reg}) : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[slr_pkg::STEP_W-2:0], fits};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == slr_pkg::DIV_CNT_W'(slr_pkg::STEP_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/slr_mix.sv
// Shared interpolation unit: one registered multiply, then round toward zero.
module slr_mix (
    input  logic                                aclk,
    input  logic                                load,
    input  logic signed [slr_pkg::SAMPLE_W-1:0] s0,
    input  logic signed [slr_pkg::SAMPLE_W-1:0] s1,
    input  logic        [slr_pkg::FRAC_W-1:0]   frac,
    output logic signed [slr_pkg::SAMPLE_W-1:0] result
);

    logic signed [slr_pkg::SAMPLE_W:0]      diff;
    logic signed [slr_pkg::FRAC_W:0]        frac_s;
    logic signed [slr_pkg::MIX_W-1:0]       prod_next;
    logic signed [slr_pkg::MIX_W-1:0]       prod_reg;
    logic signed [slr_pkg::SAMPLE_W-1:0]    s0_reg;
    logic signed [slr_pkg::MIX_W-1:0]       base;
    logic signed [slr_pkg::MIX_W-1:0]       sum;
    logic        [slr_pkg::MIX_W-1:0]       rounded;

    // s0*(ONE-f) + s1*f  ==  s0*ONE + (s1-s0)*f
    assign diff      = $signed({s1[slr_pkg::SAMPLE_W-1], s1})
                     - $signed({s0[slr_pkg::SAMPLE_W-1], s0});
    assign frac_s    = $signed({1'b0, frac});
    assign prod_next = diff * frac_s;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
            s0_reg   <= s0;
        end
    end

    // Add the scaled s0 and divide by ONE, truncating toward zero
    always_comb begin
        base    = {{(slr_pkg::MIX_W - slr_pkg::SAMPLE_W - slr_pkg::FRAC_BITS)
                    {s0_reg[slr_pkg::SAMPLE_W-1]}},
                   s0_reg, {slr_pkg::FRAC_BITS{1'b0}}};
        sum     = base + prod_reg;
        rounded = sum[slr_pkg::MIX_W-1] ? (sum + slr_pkg::MIX_W'(slr_pkg::ONE - 1)) : sum;
        result  = rounded[slr_pkg::FRAC_BITS +: slr_pkg::SAMPLE_W];
    end

endmodule

### hdl/stereo_linear_resampler.sv
// Stereo linear-interpolation resampler: sequencer around a divider and a mix unit.
//
//  channel  | ports    | tdata (low bit up)                              | side bits
//  ---------+----------+-------------------------------------------------+----------------------
//  input    | s_t*     | left_in, right_in, block_frames, out_frames     | tuser: op
//  result   | m_t*     | left_out, right_out                             | tlast: last_of_run,
//           |          |                                                 | tuser: end_of_block
//
//  A frame that opens a block passes through the step divider first.
//  Each result then goes through check, two passes through the shared multiplier, hold
//  and hand-off, and each frame adds the idle step, a closing check and a finish step.
//  s_tready is high only while the sequencer is idle; a clear request is handled in idle.
//  A stalled result channel holds the sequencer at its hand-off step.
//  Reset is synchronous on aresetn low and zeroes history, phase and block position.
module stereo_linear_resampler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // left_in[15:0], right_in[31:16], block_frames[42:32],
                                   // out_frames[56:43], zero fill
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_out[15:0], right_out[31:16]
    output logic        m_tlast,
    output logic        m_tuser    // end_of_block
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_MUL_L,
        ST_MUL_R,
        ST_HOLD,
        ST_PUSH_MID,
        ST_PUSH_LAST,
        ST_FIN
    } state_t;

    localparam int SW = slr_pkg::SAMPLE_W;
    localparam int BW = slr_pkg::BLOCK_W;
    localparam int OW = slr_pkg::OUT_W;
    localparam int PW = slr_pkg::PHASE_W;
    localparam int FB = slr_pkg::FRAC_BITS;
    localparam logic signed [PW-1:0] ONE_P = PW'(slr_pkg::ONE);

    state_t                                state_reg;
    logic signed [SW-1:0]                  in_l_reg, in_r_reg;
    logic signed [SW-1:0]                  prev_l_reg, prev_r_reg;
    logic signed [slr_pkg::SAVED_W-1:0]    saved_reg;
    logic signed [PW-1:0]                  phase_reg;
    logic [slr_pkg::STEP_W-1:0]            step_reg;
    logic [BW-1:0]                         frame_index_reg;
    logic [OW-1:0]                         done_cnt_reg;
    logic [BW-1:0]                         block_len_reg;
    logic [OW-1:0]                         out_len_reg;
    logic [slr_pkg::RES_CNT_W-1:0]         n_reg;
    logic                                  pend_reg;
    logic [slr_pkg::FRAC_W-1:0]            f_reg;
    logic signed [SW-1:0]                  res_l_reg, res_r_reg;
    logic                                  res_eob_reg;
    logic                                  m_tvalid_reg;
    logic [31:0]                           m_tdata_reg;
    logic                                  m_tlast_reg;
    logic                                  m_tuser_reg;

    // Input field decode and size clamping
    logic [BW-1:0]  bf_raw, bf;
    logic [OW-1:0]  of_raw, of_cap, of_clamped;
    logic           accept;

    assign accept = s_tvalid && s_tready;
    assign bf_raw = s_tdata[42:32];
    assign of_raw = s_tdata[56:43];

    always_comb begin
        if (bf_raw == '0) begin
            bf = BW'(1);
        end else if (bf_raw > BW'(slr_pkg::MAX_FRAMES)) begin
            bf = BW'(slr_pkg::MAX_FRAMES);
        end else begin
            bf = bf_raw;
        end
        of_cap = OW'(bf * slr_pkg::MAX_UPSAMPLE);
        if (of_raw == '0) begin
            of_clamped = OW'(1);
        end else if (of_raw > of_cap) begin
            of_clamped = of_cap;
        end else begin
            of_clamped = of_raw;
        end
    end

    // Step divider
    logic                           div_start;
    logic                           div_done;
    logic [slr_pkg::STEP_W-1:0]     div_quo;

    assign div_start = accept && (s_tuser == slr_pkg::OP_FRAME) && (frame_index_reg == '0);

    slr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({bf, {FB{1'b0}}}),
        .divisor  (of_clamped),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Shared mix unit: left pass, then right pass
    logic                 mix_load;
    logic signed [SW-1:0] mix_s0, mix_s1, mix_res;

    assign mix_load = (state_reg == ST_MUL_L) || (state_reg == ST_MUL_R);
    assign mix_s0   = (state_reg == ST_MUL_L) ? prev_l_reg : prev_r_reg;
    assign mix_s1   = (state_reg == ST_MUL_L) ? in_l_reg : in_r_reg;

    slr_mix u_mix (
        .aclk   (aclk),
        .load   (mix_load),
        .s0     (mix_s0),
        .s1     (mix_s1),
        .frac   (f_reg),
        .result (mix_res)
    );

    // Per-output decision: phase compare and weight
    logic signed [PW-1:0]      k_one, f_diff, end_phase;
    logic                      below, last_frame, emit;
    logic [slr_pkg::FRAC_W-1:0] f_calc;
    logic signed [slr_pkg::SAVED_W-1:0] saved_calc;

    always_comb begin
        k_one      = $signed({1'b0, frame_index_reg, {FB{1'b0}}});
        below      = phase_reg < k_one;
        f_diff     = phase_reg - (k_one - ONE_P);
        last_frame = ({1'b0, frame_index_reg} + 1'b1) >= {1'b0, block_len_reg};
        emit       = (done_cnt_reg < out_len_reg)
                  && (n_reg < slr_pkg::RES_CNT_W'(slr_pkg::MAX_RESULTS))
                  && (last_frame || below);
        if (!below || f_diff > ONE_P) begin
            f_calc = slr_pkg::FRAC_W'(slr_pkg::ONE);
        end else if (f_diff[PW-1]) begin
            f_calc = '0;
        end else begin
            f_calc = f_diff[slr_pkg::FRAC_W-1:0];
        end
        end_phase = phase_reg - $signed({1'b0, block_len_reg, {FB{1'b0}}});
        if (!end_phase[PW-1]) begin
            saved_calc = '0;
        end else if (end_phase < -ONE_P) begin
            saved_calc = -slr_pkg::SAVED_W'(slr_pkg::ONE);
        end else begin
            saved_calc = end_phase[slr_pkg::SAVED_W-1:0];
        end
    end

    logic out_free;
    logic push_ok;
    assign out_free = !m_tvalid_reg || m_tready;
    assign push_ok  = ((state_reg == ST_PUSH_MID) || (state_reg == ST_PUSH_LAST)) && out_free;

    // Sequencer, state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            prev_l_reg      <= '0;
            prev_r_reg      <= '0;
            saved_reg       <= '0;
            phase_reg       <= '0;
            step_reg        <= '0;
            frame_index_reg <= '0;
            done_cnt_reg    <= '0;
            block_len_reg   <= '0;
            out_len_reg     <= '0;
            n_reg           <= '0;
            pend_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            // Output register: load on hand-off, empty once taken
            if (push_ok) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg) inside
                ST_IDLE: begin
                    if (accept) begin
                        in_l_reg <= s_tdata[15:0];
                        in_r_reg <= s_tdata[31:16];
                        n_reg    <= '0;
                        pend_reg <= 1'b0;
                        if (s_tuser == slr_pkg::OP_CLEAR) begin
                            prev_l_reg      <= '0;
                            prev_r_reg      <= '0;
                            saved_reg       <= '0;
                            frame_index_reg <= '0;
                            done_cnt_reg    <= '0;
                        end else if (frame_index_reg == '0) begin
                            block_len_reg <= bf;
                            out_len_reg   <= of_clamped;
                            phase_reg     <= {{(PW - slr_pkg::SAVED_W){saved_reg[slr_pkg::SAVED_W-1]}},
                                              saved_reg};
                            done_cnt_reg  <= '0;
                            state_reg     <= ST_DIV;
                        end else begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        step_reg  <= div_quo;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    f_reg <= f_calc;
                    if (emit) begin
                        state_reg <= pend_reg ? ST_PUSH_MID : ST_MUL_L;
                    end else begin
                        state_reg <= pend_reg ? ST_PUSH_LAST : ST_FIN;
                    end
                end
                ST_MUL_L: begin
                    state_reg <= ST_MUL_R;
                end
                ST_MUL_R: begin
                    res_l_reg <= mix_res;
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    res_r_reg    <= mix_res;
                    res_eob_reg  <= (done_cnt_reg + 1'b1) == out_len_reg;
                    pend_reg     <= 1'b1;
                    done_cnt_reg <= done_cnt_reg + 1'b1;
                    n_reg        <= n_reg + 1'b1;
                    phase_reg    <= phase_reg + $signed({1'b0, step_reg});
                    state_reg    <= ST_CHECK;
                end
                ST_PUSH_MID, ST_PUSH_LAST: begin
                    if (out_free) begin
                        m_tdata_reg  <= {res_r_reg, res_l_reg};
                        m_tlast_reg  <= (state_reg == ST_PUSH_LAST);
                        m_tuser_reg  <= res_eob_reg;
                        pend_reg     <= 1'b0;
                        state_reg    <= (state_reg == ST_PUSH_LAST) ? ST_FIN : ST_MUL_L;
                    end
                end
                ST_FIN: begin
                    prev_l_reg <= in_l_reg;
                    prev_r_reg <= in_r_reg;
                    if (last_frame) begin
                        saved_reg       <= saved_calc;
                        frame_index_reg <= '0;
                    end else begin
                        frame_index_reg <= frame_index_reg + 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // Divider completion always resumes the output loop
    a_div_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_done) |=> (state_reg == ST_CHECK))
        else $error("divider finish did not reach the check step");

    // Never more outputs than the block asked for
    a_done_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_cnt_reg <= out_len_reg))
        else $error("output count exceeds block output length");

    // Saved phase stays within [-ONE, 0]
    a_saved_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (saved_reg <= 0) && (saved_reg >= -slr_pkg::SAVED_W'(slr_pkg::ONE)))
        else $error("saved phase out of range");

    // A result only leaves the hold step once its right sample is captured
    a_hold_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |=> (pend_reg && state_reg == ST_CHECK))
        else $error("held result not marked pending");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the stereo linear resampler with a built-in frame predictor.
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 150;   // longest block-opening frame plus margin
    localparam int TOTAL_FRAMES = 470;
    localparam int PRINT_LIMIT  = 40;

    // One input transfer
    typedef struct {
        logic                                op;
        logic signed [slr_pkg::SAMPLE_W-1:0] left;
        logic signed [slr_pkg::SAMPLE_W-1:0] right;
        logic [slr_pkg::BLOCK_W-1:0]         blk;
        logic [slr_pkg::OUT_W-1:0]           outs;
    } frame_t;

    // One output transfer
    typedef struct {
        logic signed [slr_pkg::SAMPLE_W-1:0] left;
        logic signed [slr_pkg::SAMPLE_W-1:0] right;
        logic                                last_run;
        logic                                eob;
    } out_frame_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;  // left_in[15:0], right_in[31:16], block_frames[42:32],
                                 // out_frames[56:43], zero fill
    logic        s_tuser  = 1'b0; // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // left_out[15:0], right_out[31:16]
    logic        m_tlast;        // last_of_run
    logic        m_tuser;        // end_of_block

    out_frame_t  pending_out[$];
    int          errors       = 0;
    int          frames_sent  = 0;
    int          rx_hold      = 0;
    int          quiet_cycles = 0;
    bit          tx_calm      = 1'b0;
    bit          rx_calm      = 1'b0;

    // Predictor state
    logic signed [slr_pkg::SAMPLE_W-1:0] hist_l     = '0;
    logic signed [slr_pkg::SAMPLE_W-1:0] hist_r     = '0;
    longint                              saved_ph   = 0;
    longint                              phase      = 0;
    longint                              step       = 0;
    int unsigned                         frame_idx  = 0;
    int unsigned                         done_cnt   = 0;
    int unsigned                         blk_len    = 0;
    int unsigned                         out_len    = 0;

    stereo_linear_resampler DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Weighted mix of two samples, truncated toward zero
    function automatic longint blend(input longint s0, input longint s1, input longint f);
        return (s0 * (slr_pkg::ONE - f) + s1 * f) / slr_pkg::ONE;
    endfunction

    // Advance the predictor by one accepted transfer and queue the outputs it causes
    function automatic void resample_frame(input frame_t fr);
        out_frame_t  run[$];
        out_frame_t  o;
        int unsigned bf;
        int unsigned of;
        int unsigned k;
        bit          fin;
        longint      f;
        longint      lo;
        longint      ro;
        longint      s;

        if (fr.op == slr_pkg::OP_CLEAR) begin
            hist_l    = '0;
            hist_r    = '0;
            saved_ph  = 0;
            frame_idx = 0;
            done_cnt  = 0;
            return;
        end

        // Latch sizes on the block's opening frame
        if (frame_idx == 0) begin
            bf = fr.blk;
            of = fr.outs;
            if (bf < 1) bf = 1;
            if (bf > slr_pkg::MAX_FRAMES) bf = slr_pkg::MAX_FRAMES;
            if (of < 1) of = 1;
            if (of > slr_pkg::MAX_UPSAMPLE * bf) of = slr_pkg::MAX_UPSAMPLE * bf;
            blk_len  = bf;
            out_len  = of;
            step     = (longint'(bf) << slr_pkg::FRAC_BITS) / longint'(of);
            phase    = saved_ph;
            done_cnt = 0;
        end

        k   = frame_idx;
        fin = (k + 1 >= blk_len);

        while (done_cnt < out_len && run.size() < slr_pkg::MAX_RESULTS &&
               (fin || phase < longint'(k) * slr_pkg::ONE)) begin
            if (phase >= longint'(k) * slr_pkg::ONE) begin
                // leftover output on the closing frame repeats it
                lo = fr.left;
                ro = fr.right;
            end else begin
                f = phase - (longint'(k) - 1) * slr_pkg::ONE;
                if (f < 0) f = 0;
                if (f > slr_pkg::ONE) f = slr_pkg::ONE;
                lo = blend(hist_l, fr.left, f);
                ro = blend(hist_r, fr.right, f);
            end
            o.left     = lo[slr_pkg::SAMPLE_W-1:0];
            o.right    = ro[slr_pkg::SAMPLE_W-1:0];
            o.last_run = 1'b0;
            done_cnt++;
            o.eob      = (done_cnt == out_len);
            phase     += step;
            run.push_back(o);
        end
        if (run.size() != 0) run[run.size()-1].last_run = 1'b1;
        foreach (run[i]) pending_out.push_back(run[i]);

        hist_l = fr.left;
        hist_r = fr.right;

        // Carry the phase overshoot into the next block
        if (fin) begin
            s = phase - longint'(blk_len) * slr_pkg::ONE;
            if (s > 0) s = 0;
            if (s < -slr_pkg::ONE) s = -slr_pkg::ONE;
            saved_ph  = s;
            frame_idx = 0;
        end else begin
            frame_idx = k + 1;
        end
    endfunction

    // Compare one output transfer with the oldest prediction
    task automatic check_sample(input logic [31:0] data, input logic last, input logic eob);
        out_frame_t want;
        if (pending_out.size() == 0) begin
            report_mismatch($sformatf("output with none pending: L=%0d R=%0d",
                                      $signed(data[15:0]), $signed(data[31:16])));
            return;
        end
        want = pending_out.pop_front();
        if (data[15:0] !== want.left)
            report_mismatch($sformatf("left_out %0d, predicted %0d",
                                      $signed(data[15:0]), want.left));
        if (data[31:16] !== want.right)
            report_mismatch($sformatf("right_out %0d, predicted %0d",
                                      $signed(data[31:16]), want.right));
        if (last !== want.last_run)
            report_mismatch($sformatf("last_of_run %b, predicted %b", last, want.last_run));
        if (eob !== want.eob)
            report_mismatch($sformatf("end_of_block %b, predicted %b", eob, want.eob));
    endtask

    // Result side: check each transfer, then stall a random number of cycles
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            check_sample(m_tdata, m_tlast, m_tuser);
            rx_hold = rx_calm ? 0 : $urandom_range(0, 15);
            m_tready <= (rx_hold == 0);
        end else if (rx_hold != 0) begin
            rx_hold--;
            m_tready <= (rx_hold == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on transfer activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [slr_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return slr_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // Output count for a block: zero, over range, 1:1, down- or upsampling
    function automatic logic [slr_pkg::OUT_W-1:0] rand_out(input int unsigned bf);
        int unsigned span;
        span = (bf == 0) ? 1 : bf;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return slr_pkg::OUT_W'($urandom_range(0, (1 << slr_pkg::OUT_W) - 1));
            2:       return slr_pkg::OUT_W'(span);
            3:       return slr_pkg::OUT_W'($urandom_range(1, span));
            default: return slr_pkg::OUT_W'($urandom_range(1, slr_pkg::MAX_UPSAMPLE * span));
        endcase
    endfunction

    // Send one item, waiting a random gap first; valid stays high across back-to-back items
    task automatic send_frame(input logic op,
                              input logic signed [slr_pkg::SAMPLE_W-1:0] l,
                              input logic signed [slr_pkg::SAMPLE_W-1:0] r,
                              input logic [slr_pkg::BLOCK_W-1:0] bf,
                              input logic [slr_pkg::OUT_W-1:0] of);
        frame_t      fr;
        int unsigned gap;
        fr.op    = op;
        fr.left  = l;
        fr.right = r;
        fr.blk   = bf;
        fr.outs  = of;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, of, bf, r, l};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        resample_frame(fr);
        if (op == slr_pkg::OP_FRAME) frames_sent++;
    endtask

    task automatic send_clear();
        send_frame(slr_pkg::OP_CLEAR, rand_sample(), rand_sample(),
                   slr_pkg::BLOCK_W'($urandom), slr_pkg::OUT_W'($urandom));
    endtask

    // Frames of one block; only the opening frame carries meaningful sizes
    task automatic send_block(input int unsigned bf, input logic [slr_pkg::OUT_W-1:0] of,
                              input int unsigned count);
        for (int i = 0; i < count; i++) begin
            if (i == 0)
                send_frame(slr_pkg::OP_FRAME, rand_sample(), rand_sample(),
                           slr_pkg::BLOCK_W'(bf), of);
            else
                send_frame(slr_pkg::OP_FRAME, rand_sample(), rand_sample(),
                           slr_pkg::BLOCK_W'($urandom), slr_pkg::OUT_W'($urandom));
        end
    endtask

    // Hold off the sender until every predicted output has been seen
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_out.size() != 0);
    endtask

    // Blocks straight out of reset, history starts at zero
    task automatic test_first_blocks();
        send_block(1, 1, 1);
        send_block(2, 3, 2);
    endtask

    // Zero sizes, saturated output count, exact maximum upsampling
    task automatic test_size_limits();
        send_block(0, 0, 1);
        send_block(2, 14'h3FFF, 2);
        send_block(3, 24, 3);
    endtask

    // Frames that produce no output
    task automatic test_downsample();
        send_block(4, 1, 4);
        send_block(3, 2, 3);
    endtask

    // Full-scale samples of both signs
    task automatic test_sample_extremes();
        send_frame(slr_pkg::OP_FRAME, 16'sh8000, 16'sh7FFF, 3, 7);
        send_frame(slr_pkg::OP_FRAME, 16'sh7FFF, 16'sh8000, 3, 7);
        send_frame(slr_pkg::OP_FRAME, 16'sh8000, 16'sh8000, 3, 7);
    endtask

    // Oversized block abandoned by a clear, then a clear while idle
    task automatic test_clear_midblock();
        send_block(11'h7FF, 14'h3FFF, 3);
        send_clear();
        send_clear();
        wait_for_drain();
    endtask

    // Mostly whole blocks with random content, some noise and broken blocks
    task automatic test_random_traffic();
        int unsigned bf;
        int unsigned pick;
        int          next_drain;
        next_drain = frames_sent + $urandom_range(40, 90);
        while (frames_sent < TOTAL_FRAMES) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            pick    = $urandom_range(0, 99);
            if (pick < 6) begin
                send_clear();
            end else if (pick < 12) begin
                bf = $urandom_range(2, 24);
                send_block(bf, rand_out(bf), $urandom_range(1, bf - 1));
                send_clear();
            end else if (pick < 16) begin
                bf = $urandom_range(16, 48);
                send_block(bf, rand_out(bf), bf);
            end else begin
                bf = $urandom_range(0, 8);
                send_block(bf, rand_out(bf), (bf == 0) ? 1 : bf);
            end
            if (frames_sent >= next_drain) begin
                wait_for_drain();
                next_drain = frames_sent + $urandom_range(40, 90);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_blocks();
        test_size_limits();
        test_downsample();
        test_sample_extremes();
        test_clear_midblock();
        test_random_traffic();

        // Drain, then watch for stray outputs
        wait_for_drain();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
